// ===== sv/bre_pkg.sv =====
// types and constants shared across the black run extractor
package bre_pkg;

  localparam int POS_W      = 14;
  localparam int START_W    = 10;
  localparam int CNT_W      = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;

  typedef struct packed {
    logic [7:0] pixel_byte;
    logic       first_of_line;
    logic       last_of_line;
  } in_item_t;

  typedef struct packed {
    logic [POS_W-1:0] seg_left;
    logic [POS_W-1:0] seg_right;
  } out_item_t;

  typedef struct packed {
    logic             first;
    logic             last;
    logic             all_black;
    logic [CNT_W-1:0] lead;
    logic [CNT_W-1:0] trail;
  } cls_t;

endpackage

// ===== sv/black_run_extractor.sv =====
// top level of the black run extractor
//
//  channel  dir  handshake          beat
//  in       in   in_valid/in_stall   pixel byte, first and last of line
//  out      out  out_valid/out_stall run left and right pixel position
//  cfg      in   cfg_valid/cfg_ready register index and write data
//
// one byte beat per cycle while in_stall is low; each beat is written into the
// two entry queue and its run is loaded into the result register as it leaves,
// so out_valid rises once the closing byte has left the queue
// start_byte is reduced modulo LINE_BYTES as it is written; cfg_ready is always high
// rst clears the queue, the run state and the result register
// out_stall holds the result register while out_valid is high; the queue holds up to two beats
module black_run_extractor #(
  parameter int LINE_BYTES = 1024
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bre_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bre_pkg::out_item_t             out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bre_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bre_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bre_pkg::*;

  localparam int IDX_W = $clog2(LINE_BYTES);

  logic [IDX_W-1:0] start_mod;
  logic [POS_W-1:0] min_length;
  logic             q_full;
  logic             q_push;
  logic             q_pop;
  logic             q_valid;
  cls_t             q_in;
  cls_t             q_head;

  bre_cfg #(.LINE_BYTES(LINE_BYTES)) u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .start_mod (start_mod),
    .min_length(min_length)
  );

  bre_front u_front (
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .q_full  (q_full),
    .q_push  (q_push),
    .q_data  (q_in)
  );

  bre_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  bre_back #(.LINE_BYTES(LINE_BYTES)) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .start_mod (start_mod),
    .min_length(min_length),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_start_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(start_mod) < 32'(LINE_BYTES))
    else $error("reduced start byte out of range");

  a_run_long_enough: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (POS_W'(out_data.seg_right - out_data.seg_left) >= min_length))
    else $error("result shorter than minimum length");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled run beat changed");

endmodule

// ===== sv/bre_cfg.sv =====
// configuration registers and start byte modulo reduction
module bre_cfg #(
  parameter int LINE_BYTES = 1024
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [bre_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bre_pkg::CFG_DATA_W-1:0]       cfg_data,
  output logic [$clog2(LINE_BYTES)-1:0]        start_mod,
  output logic [bre_pkg::POS_W-1:0]            min_length
);
  import bre_pkg::*;

  localparam int IDX_W = $clog2(LINE_BYTES);
  localparam int MUL_W = 2 * START_W + 1;
  localparam int SHIFT = START_W + IDX_W;
  localparam logic [MUL_W-1:0] DIV   = MUL_W'(LINE_BYTES);
  localparam logic [MUL_W-1:0] RECIP = MUL_W'((1 << SHIFT) / LINE_BYTES);

  logic [MUL_W-1:0] data_w;
  logic [MUL_W-1:0] prod;
  logic [MUL_W-1:0] quot;
  logic [MUL_W-1:0] rem_raw;
  logic [MUL_W-1:0] rem_fix;
  logic             wr;

  assign cfg_ready = 1'b1;
  assign wr        = cfg_valid && cfg_ready;

  // reciprocal estimate is low by at most one, one subtract corrects it
  assign data_w  = MUL_W'(cfg_data[START_W-1:0]);
  assign prod    = data_w * RECIP;
  assign quot    = prod >> SHIFT;
  assign rem_raw = data_w - quot * DIV;
  assign rem_fix = (rem_raw >= DIV) ? rem_raw - DIV : rem_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_mod  <= '0;
      min_length <= '0;
    end else if (wr) begin
      unique case (cfg_index)
        REG_START_BYTE: begin
          start_mod <= rem_fix[IDX_W-1:0];
        end
        REG_MIN_LENGTH: begin
          min_length <= cfg_data[POS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== sv/bre_front.sv =====
// input side: accepts byte beats and classifies them
module bre_front (
  input  logic              in_valid,
  output logic              in_stall,
  input  bre_pkg::in_item_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output bre_pkg::cls_t     q_data
);
  import bre_pkg::*;

  function automatic logic [CNT_W-1:0] lead_black(logic [7:0] b);
    logic [CNT_W-1:0] n;
    logic             stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 7; i >= 0; i--) begin
      if (!stop) begin
        if (!b[i]) n = n + CNT_W'(1);
        else stop = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] trail_black(logic [7:0] b);
    logic [CNT_W-1:0] n;
    logic             stop;
    n    = '0;
    stop = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (!stop) begin
        if (!b[i]) n = n + CNT_W'(1);
        else stop = 1'b1;
      end
    end
    return n;
  endfunction

  assign in_stall = q_full;
  assign q_push   = in_valid && !in_stall;

  always_comb begin
    q_data.first     = in_data.first_of_line;
    q_data.last      = in_data.last_of_line;
    q_data.all_black = (in_data.pixel_byte == 8'h00);
    q_data.lead      = lead_black(in_data.pixel_byte);
    q_data.trail     = trail_black(in_data.pixel_byte);
  end

endmodule

// ===== sv/bre_queue.sv =====
// two entry queue between front and back
module bre_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  bre_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output bre_pkg::cls_t head
);
  import bre_pkg::*;

  cls_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== sv/bre_back.sv =====
// run tracking and result register
module bre_back #(
  parameter int LINE_BYTES = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          q_valid,
  input  bre_pkg::cls_t                 q_head,
  output logic                          q_pop,
  input  logic [$clog2(LINE_BYTES)-1:0] start_mod,
  input  logic [bre_pkg::POS_W-1:0]     min_length,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bre_pkg::out_item_t            out_data
);
  import bre_pkg::*;

  localparam int IDX_W = $clog2(LINE_BYTES);

  logic             in_run;
  logic             line_ended;
  logic [IDX_W-1:0] byte_index;
  logic [POS_W-1:0] run_left;
  logic [CNT_W-1:0] prior_trail;

  logic [IDX_W-1:0]       idx_next;
  logic [IDX_W+POS_W-1:0] pos_wide;
  logic [POS_W-1:0]       pos;
  logic [POS_W-1:0]       right;
  logic [POS_W-1:0]       run_len;
  logic [POS_W-1:0]       left_new;
  logic                   closes;
  logic                   opens;
  logic                   active;
  logic                   emit;

  assign q_pop    = q_valid && (!out_valid || !out_stall);
  assign idx_next = (byte_index == IDX_W'(LINE_BYTES - 1)) ? '0 : byte_index + IDX_W'(1);
  assign pos_wide = {{POS_W{1'b0}}, idx_next} << 3;
  assign pos      = pos_wide[POS_W-1:0];
  assign right    = pos + POS_W'(q_head.lead);
  assign run_len  = right - run_left;
  assign left_new = pos - POS_W'(prior_trail);
  assign active   = !q_head.first && !line_ended;
  assign closes   = in_run && (q_head.last || !q_head.all_black);
  assign opens    = !in_run && !q_head.last && q_head.all_black;
  assign emit     = active && closes && (run_len >= min_length);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_run      <= 1'b0;
      line_ended  <= 1'b1;
      byte_index  <= '0;
      run_left    <= '0;
      prior_trail <= CNT_W'(8);
      out_valid   <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= q_pop && emit;
      end
      if (q_pop) begin
        if (q_head.first) begin
          byte_index  <= start_mod;
          prior_trail <= q_head.trail;
          in_run      <= 1'b0;
          line_ended  <= q_head.last;
        end else if (!line_ended) begin
          byte_index  <= idx_next;
          prior_trail <= q_head.trail;
          // a run is open after any all-black byte that is not the last
          in_run      <= !q_head.last && q_head.all_black;
          line_ended  <= q_head.last;
          if (opens) begin
            run_left <= left_new;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) begin
      out_data.seg_left  <= run_left;
      out_data.seg_right <= right;
    end
  end

endmodule

// ===== tb/sv/black_run_checker.sv =====
// checker that predicts black runs from the byte beats and compares the run beats
module black_run_checker #(
  parameter int LINE_BYTES = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  bre_pkg::in_item_t               in_data,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  bre_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [bre_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bre_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                              mismatches,
  output int                              runs_owed,
  output int                              runs_checked
);
  import bre_pkg::*;

  logic [START_W-1:0] start_byte = '0;
  logic [POS_W-1:0]   min_length = '0;

  logic               run_open = 1'b0;
  logic [7:0]         prev_pixels = '0;
  int                 byte_pos = 0;
  logic [POS_W-1:0]   run_start = '0;
  logic               line_done = 1'b1;

  out_item_t          runs_due[$];

  initial begin
    mismatches = 0;
    runs_owed = 0;
    runs_checked = 0;
  end

  function automatic int lead_black(logic [7:0] b);
    int n;
    n = 0;
    while (n < 8 && !b[7-n]) n++;
    return n;
  endfunction

  function automatic int trail_black(logic [7:0] b);
    int n;
    n = 0;
    while (n < 8 && !b[n]) n++;
    return n;
  endfunction

  function automatic void take_byte(in_item_t it);
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] right;
    logic [POS_W-1:0] span;
    out_item_t        run;
    if (it.first_of_line) begin
      byte_pos = int'(start_byte) % LINE_BYTES;
      prev_pixels = it.pixel_byte;
      run_open = 1'b0;
      line_done = it.last_of_line;
      return;
    end
    if (line_done) return;
    byte_pos = (byte_pos + 1 >= LINE_BYTES) ? 0 : byte_pos + 1;
    pos = POS_W'(byte_pos * 8);
    if (run_open) begin
      if (it.last_of_line || it.pixel_byte != 8'h00) begin
        right = pos + POS_W'(lead_black(it.pixel_byte));
        span = right - run_start;
        if (span >= min_length) begin
          run.seg_left = run_start;
          run.seg_right = right;
          runs_due.push_back(run);
        end
        run_open = 1'b0;
      end
    end else if (!it.last_of_line && it.pixel_byte == 8'h00) begin
      run_start = pos - POS_W'(trail_black(prev_pixels));
      run_open = 1'b1;
    end
    if (it.last_of_line) begin
      line_done = 1'b1;
      run_open = 1'b0;
    end
    prev_pixels = it.pixel_byte;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      start_byte = '0;
      min_length = '0;
      run_open = 1'b0;
      prev_pixels = '0;
      byte_pos = 0;
      run_start = '0;
      line_done = 1'b1;
      runs_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (runs_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected run beat: left %0d right %0d",
                     out_data.seg_left, out_data.seg_right);
        end else begin
          want = runs_due.pop_front();
          runs_checked++;
          if (out_data.seg_left !== want.seg_left || out_data.seg_right !== want.seg_right) begin
            mismatches++;
            if (mismatches <= 10)
              $display("run mismatch: expected left %0d right %0d, got left %0d right %0d",
                       want.seg_left, want.seg_right, out_data.seg_left, out_data.seg_right);
          end
        end
      end
      if (in_valid && !in_stall) take_byte(in_data);
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_START_BYTE: start_byte = cfg_data[START_W-1:0];
          REG_MIN_LENGTH: min_length = cfg_data;
          default: ;
        endcase
      end
    end
    runs_owed = runs_due.size();
  end

endmodule

// ===== tb/sv/black_run_extractor_test.sv =====
// stimulus, stall pattern and verdict for the black run extractor
module black_run_extractor_test;
  import bre_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int BYTE_TARGET = 1700;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_START_BYTE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int mismatches;
  int runs_owed;
  int runs_checked;
  int beats_sent = 0;
  int lines_sent = 0;
  int settings_used = 0;
  int quiet = 0;
  bit burst = 1'b0;

  black_run_extractor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  black_run_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .runs_owed(runs_owed), .runs_checked(runs_checked)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      quiet <= 0;
    else if (quiet >= QUIET_LIMIT) begin
      $display("black_run_extractor_test: errors");
      $finish;
    end else
      quiet <= quiet + 1;
  end

  // receiver: stall length drawn per beat, in stretches of one style
  initial begin
    int n;
    int style;
    int left_in_style;
    style = 0;
    left_in_style = 0;
    @(negedge rst);
    forever begin
      if (left_in_style == 0) begin
        style = $urandom_range(0, 2);
        left_in_style = $urandom_range(20, 80);
      end
      left_in_style--;
      case (style)
        0: n = 0;
        1: n = $urandom_range(0, 14);
        default: n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(8, 14);
      endcase
      if (n > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (n - 1) @(negedge clk);
        @(negedge clk) out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic push(input logic [7:0] pixels, input logic first, input logic last);
    int gap;
    gap = burst ? 0 : (($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 14));
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= '{pixel_byte: pixels, first_of_line: first, last_of_line: last};
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  task automatic drain();
    @(negedge clk) in_valid <= 1'b0;
    do @(negedge clk); while (runs_owed != 0);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(input int start, input int min_len);
    write_reg(REG_START_BYTE, {4'($urandom_range(0, 15)), START_W'(start)});
    write_reg(REG_MIN_LENGTH, CFG_DATA_W'(min_len));
    settings_used++;
  endtask

  function automatic logic [7:0] pick_pixels();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0, 1, 2, 3: return 8'h00;
      4: return 8'hFF;
      5: return 8'hFF >> $urandom_range(1, 7);
      6: return 8'hFF << $urandom_range(1, 7);
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_line();
    int n;
    bit cut;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 20);
    cut = ($urandom_range(0, 19) == 0);
    burst = ($urandom_range(0, 2) == 0);
    lines_sent++;
    if ($urandom_range(0, 24) == 0) begin
      push(pick_pixels(), 1'b1, 1'b1);
      return;
    end
    push(pick_pixels(), 1'b1, 1'b0);
    for (int i = 1; i < n; i++) push(pick_pixels(), 1'b0, 1'b0);
    if (!cut) push(pick_pixels(), 1'b0, 1'b1);
    if ($urandom_range(0, 14) == 0)
      repeat ($urandom_range(1, 3)) push(8'($urandom_range(0, 255)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int target;
    int start;
    int min_len;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    set_regs(0, 0);
    // ignored before any start byte, then an empty line
    push(8'h00, 1'b0, 1'b0);
    push(8'h00, 1'b1, 1'b1);
    // run pulled back by trailing black and extended by leading black
    push(8'hF0, 1'b1, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'h07, 1'b0, 1'b0);
    push(8'h55, 1'b0, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'hFF, 1'b0, 1'b0);
    push(8'h00, 1'b0, 1'b1);
    // restart during a run drops it
    push(8'h00, 1'b1, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'hFF, 1'b1, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'h80, 1'b0, 1'b1);
    // all-black last byte closes a run
    push(8'hAA, 1'b1, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'h00, 1'b0, 1'b1);
    drain();

    // run across the index wrap, long enough for the largest minimum
    set_regs(1020, 8192);
    push(8'hFE, 1'b1, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'h00, 1'b0, 1'b0);
    push(8'h3F, 1'b0, 1'b1);

    for (int p = 0; p < 8; p++) begin
      drain();
      case (p)
        0: begin start = 0; min_len = 0; end
        1: begin start = 1023; min_len = 0; end
        2: begin start = 1015; min_len = 8192; end
        3: begin start = 1023; min_len = 8; end
        default: begin
          start = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 1023)
                                              : $urandom_range(1000, 1023);
          min_len = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8192)
                                                : $urandom_range(0, 40);
        end
      endcase
      set_regs(start, min_len);
      target = beats_sent + BYTE_TARGET / 8;
      while (beats_sent < target) send_line();
    end
    drain();

    $display("%0d byte beats in %0d lines over %0d register settings, %0d runs compared",
             beats_sent, lines_sent, settings_used, runs_checked);
    if (runs_owed != 0)
      $display("%0d runs never arrived", runs_owed);
    if (mismatches == 0 && runs_owed == 0)
      $display("black_run_extractor_test: clean");
    else
      $display("black_run_extractor_test: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
sv/bre_pkg.sv
sv/bre_cfg.sv
sv/bre_front.sv
sv/bre_queue.sv
sv/bre_back.sv
sv/black_run_extractor.sv
tb/sv/black_run_checker.sv
tb/sv/black_run_extractor_test.sv
